// ----- sv/ess_pkg.sv -----
package ess_pkg;

  localparam int TRACK_W = 16;
  localparam int CFG_W = 17;
  localparam int SUM_W = 22;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH_DEF = 32;

  localparam logic [TRACK_W-1:0] TRACK_MAX = {TRACK_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_TRACKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP = 2'd2;

  localparam logic [TRACK_W-1:0] START_HEAD_RST = '0;
  localparam logic [CFG_W-1:0] DISK_TRACKS_RST = 17'd65536;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [TRACK_W-1:0] from_track;
    logic [TRACK_W-1:0] to_track;
    logic [TRACK_W-1:0] seek_distance;
    logic [SUM_W-1:0]   run_total;
    logic               last_move;
  } res_t;

  // Chain operations; rot_down moves every entry toward cell 0, rot_up away from it.
  typedef enum logic [2:0] {
    CH_HOLD     = 3'd0,
    CH_INSERT   = 3'd1,
    CH_ROT_DOWN = 3'd2,
    CH_ROT_UP   = 3'd3,
    CH_CLEAR    = 3'd4
  } chain_mode_t;

  typedef struct packed {
    chain_mode_t        mode;
    logic [TRACK_W-1:0] ins_track;
  } chain_ctrl_t;

endpackage

// ----- sv/ess_cell.sv -----
module ess_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  ess_pkg::chain_ctrl_t        ctrl,
  input  logic                        prev_greater,
  input  logic [ess_pkg::TRACK_W-1:0] lo_val,
  input  logic                        lo_valid,
  input  logic [ess_pkg::TRACK_W-1:0] hi_val,
  input  logic                        hi_valid,
  output logic [ess_pkg::TRACK_W-1:0] val,
  output logic                        valid,
  output logic                        greater
);
  import ess_pkg::*;

  // An empty cell counts as larger than any request.
  assign greater = !valid || (val > ctrl.ins_track);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.mode)
        CH_INSERT: begin
          if (greater) begin
            if (prev_greater) begin
              valid <= lo_valid;
            end else begin
              valid <= 1'b1;
            end
          end
        end
        CH_ROT_DOWN: valid <= hi_valid;
        CH_ROT_UP:   valid <= lo_valid;
        CH_CLEAR:    valid <= 1'b0;
        default:     valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      CH_INSERT: begin
        if (greater) begin
          if (prev_greater) begin
            val <= lo_val;
          end else begin
            val <= ctrl.ins_track;
          end
        end
      end
      CH_ROT_DOWN: val <= hi_val;
      CH_ROT_UP:   val <= lo_val;
      default:     val <= val;
    endcase
  end

endmodule

// ----- sv/ess_chain.sv -----
module ess_chain #(
  parameter int QUEUE_DEPTH = ess_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ess_pkg::chain_ctrl_t        ctrl,
  output logic [ess_pkg::TRACK_W-1:0] low_val,
  output logic                        low_valid,
  output logic [ess_pkg::TRACK_W-1:0] top_val,
  output logic                        top_valid
);
  import ess_pkg::*;

  logic [TRACK_W-1:0] vals [QUEUE_DEPTH];
  logic               valids [QUEUE_DEPTH];
  logic               gts [QUEUE_DEPTH];

  // Cells form a ring so that a full rotation restores the sorted order.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int LO = (i == 0) ? QUEUE_DEPTH - 1 : i - 1;
    localparam int HI = (i == QUEUE_DEPTH - 1) ? 0 : i + 1;
    logic prev_gt;

    if (i == 0) begin : g_first
      assign prev_gt = 1'b0;
    end else begin : g_rest
      assign prev_gt = gts[LO];
    end

    ess_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .prev_greater (prev_gt),
      .lo_val       (vals[LO]),
      .lo_valid     (valids[LO]),
      .hi_val       (vals[HI]),
      .hi_valid     (valids[HI]),
      .val          (vals[i]),
      .valid        (valids[i]),
      .greater      (gts[i])
    );
  end

  assign low_val   = vals[0];
  assign low_valid = valids[0];
  assign top_val   = vals[QUEUE_DEPTH-1];
  assign top_valid = valids[QUEUE_DEPTH-1];

endmodule

// ----- sv/elevator_seek_scheduler.sv -----
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// request   | start, busy, request                    | taken when start && !busy
// result    | strobe, result                          | one cycle per move, no back-pressure
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when cfg_valid && cfg_ready
//
// A request without the last flag is inserted in sorted place into the cell
// chain, unless the chain is full, when it is dropped. A last request starts
// the schedule, which keeps busy high through two full rotations of the chain
// (one per sweep), the edge move, a drain state and a flush state; the final
// move comes out in the same cycle that busy falls.
// Reset (rst, synchronous) empties the chain and loads defaults; results cannot stall.
module elevator_seek_scheduler #(
  parameter int QUEUE_DEPTH = ess_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ess_pkg::req_t                 request,
  output logic                          strobe,
  output ess_pkg::res_t                 result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ess_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ess_pkg::CFG_W-1:0]     cfg_data
);
  import ess_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PASS1 = 6'b000010,
    ST_EDGE  = 6'b000100,
    ST_PASS2 = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [TRACK_W-1:0] start_head;
  logic [CFG_W-1:0]   disk_tracks;
  logic               sweep_up;

  // Batch state.
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   step;
  logic [TRACK_W-1:0] edge_track;
  logic [TRACK_W-1:0] head0;
  logic               dir_up;

  // Move pipeline: candidate, then the working head and sum, then one pending move.
  logic [TRACK_W-1:0] cand_to;
  logic               cand_en;
  logic [TRACK_W-1:0] head;
  logic [SUM_W-1:0]   sum;
  res_t               pending;
  logic               pending_valid;

  chain_ctrl_t        ctrl;
  logic [TRACK_W-1:0] low_val, top_val;
  logic               low_valid, top_valid;

  logic               accept;
  logic [CFG_W-1:0]   dt_m1;
  logic [TRACK_W-1:0] edge_calc;
  logic [TRACK_W-1:0] h0_calc;
  logic               read_low;
  logic [TRACK_W-1:0] rd_val;
  logic               rd_valid;
  logic [TRACK_W-1:0] clamped;
  logic               in_sweep;
  logic [TRACK_W-1:0] seek_len;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // Hold configuration; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_head  <= START_HEAD_RST;
      disk_tracks <= DISK_TRACKS_RST;
      sweep_up    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_HEAD:  start_head  <= cfg_data[TRACK_W-1:0];
        CFG_DISK_TRACKS: disk_tracks <= cfg_data;
        CFG_SWEEP_UP:    sweep_up    <= cfg_data[0];
        default:         start_head  <= start_head;
      endcase
    end
  end

  // Edge track is disk_tracks-1 saturated to the track range; zero tracks acts as one.
  assign dt_m1 = disk_tracks - CFG_W'(1);
  always_comb begin
    if (disk_tracks == '0) begin
      edge_calc = '0;
    end else if (dt_m1 > CFG_W'(TRACK_MAX)) begin
      edge_calc = TRACK_MAX;
    end else begin
      edge_calc = dt_m1[TRACK_W-1:0];
    end
    h0_calc = (start_head > edge_calc) ? edge_calc : start_head;
  end

  // Ascending reads come off cell 0 while rotating down, descending ones off the top cell.
  assign read_low = (state == ST_PASS1) ? dir_up : !dir_up;
  assign rd_val   = read_low ? low_val : top_val;
  assign rd_valid = read_low ? low_valid : top_valid;

  always_comb begin
    ctrl.ins_track = request.track;
    ctrl.mode      = CH_HOLD;
    unique case (state)
      ST_IDLE: begin
        if (accept && (count < CNT_FULL)) begin
          ctrl.mode = CH_INSERT;
        end
      end
      ST_PASS1, ST_PASS2: ctrl.mode = read_low ? CH_ROT_DOWN : CH_ROT_UP;
      ST_FLUSH:           ctrl.mode = CH_CLEAR;
      default:            ctrl.mode = CH_HOLD;
    endcase
  end

  ess_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .low_val   (low_val),
    .low_valid (low_valid),
    .top_val   (top_val),
    .top_valid (top_valid)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && request.last) begin
          state_next = ST_PASS1;
        end
      end
      ST_PASS1: begin
        if (step == STEP_LAST) begin
          state_next = ST_EDGE;
        end
      end
      ST_EDGE: state_next = ST_PASS2;
      ST_PASS2: begin
        if (step == STEP_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        step <= '0;
        if (accept && (count < CNT_FULL)) begin
          count <= count + CNT_W'(1);
        end
      end else if ((state == ST_PASS1) || (state == ST_PASS2)) begin
        step <= (step == STEP_LAST) ? '0 : step + CNT_W'(1);
      end else if (state == ST_FLUSH) begin
        count <= '0;
      end
    end
  end

  // Latch the batch geometry when the closing request arrives.
  always_ff @(posedge clk) begin
    if (accept && request.last) begin
      edge_track <= edge_calc;
      head0      <= h0_calc;
      dir_up     <= sweep_up;
    end
  end

  // Candidate stage: clamp the entry read from the chain and pick the sweep it belongs to.
  assign clamped  = (rd_val > edge_track) ? edge_track : rd_val;
  assign in_sweep = dir_up ? (clamped >= head0) : (clamped <= head0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_en <= 1'b0;
    end else begin
      unique case (state)
        ST_PASS1: cand_en <= rd_valid && in_sweep;
        ST_PASS2: cand_en <= rd_valid && !in_sweep;
        ST_EDGE:  cand_en <= 1'b1;
        default:  cand_en <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EDGE) begin
      cand_to <= dir_up ? edge_track : '0;
    end else begin
      cand_to <= clamped;
    end
  end

  // Move stage: distance and saturating running total.
  assign seek_len = (cand_to >= head) ? (cand_to - head) : (head - cand_to);
  assign sum_wide = {1'b0, sum} + (SUM_W + 1)'(seek_len);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && request.last) begin
      head <= h0_calc;
      sum  <= '0;
    end else if (cand_en) begin
      head <= cand_to;
      sum  <= sum_sat;
    end
  end

  // Keep one move pending so the final one can carry last_move.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else if (accept && request.last) begin
      pending_valid <= 1'b0;
    end else if (cand_en) begin
      pending_valid <= 1'b1;
    end else if (state == ST_FLUSH) begin
      pending_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_en) begin
      pending.from_track    <= head;
      pending.to_track      <= cand_to;
      pending.seek_distance <= seek_len;
      pending.run_total     <= sum_sat;
      pending.last_move     <= 1'b0;
    end
  end

  // Drive results: release the pending move when a newer one arrives, or at flush as last.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cand_en && pending_valid) || ((state == ST_FLUSH) && pending_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FLUSH) begin
      result <= '{from_track:    pending.from_track,
                  to_track:      pending.to_track,
                  seek_distance: pending.seek_distance,
                  run_total:     pending.run_total,
                  last_move:     1'b1};
    end else if (cand_en) begin
      result <= pending;
    end
  end

endmodule
